// ===== src/dlms_typed_value_decoder_unit_assert.svh =====
// Assertion macros shared by the checker
`ifndef DLMS_TYPED_VALUE_DECODER_UNIT_ASSERT_SVH
`define DLMS_TYPED_VALUE_DECODER_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define DLMSTV_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("dlmstv assertion failed");

// antecedent implies consequent in the next cycle
`define DLMSTV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("dlmstv assertion failed");

`endif

// ===== src/dlmstv_pkg.sv =====
package dlmstv_pkg;

	localparam int unsigned ByteW   = 8;
	localparam int unsigned ValueW  = 64;
	localparam int unsigned StatusW = 2;
	localparam int unsigned LenW    = 4;

	localparam logic [ByteW-1:0] HeaderSkipRst = 8'd12;
	localparam logic             SignedModeRst = 1'b0;

	localparam logic [ByteW-1:0] TAG_INT8   = 8'd15;
	localparam logic [ByteW-1:0] TAG_INT16  = 8'd16;
	localparam logic [ByteW-1:0] TAG_INT32  = 8'd5;
	localparam logic [ByteW-1:0] TAG_INT64  = 8'd20;
	localparam logic [ByteW-1:0] TAG_UINT8  = 8'd17;
	localparam logic [ByteW-1:0] TAG_ENUM   = 8'd22;
	localparam logic [ByteW-1:0] TAG_UINT16 = 8'd18;
	localparam logic [ByteW-1:0] TAG_UINT32 = 8'd6;
	localparam logic [ByteW-1:0] TAG_UINT64 = 8'd21;

	typedef enum logic [StatusW-1:0] {
		STAT_OK        = 2'd0,
		STAT_ACCESS    = 2'd1,
		STAT_BAD_TAG   = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		PH_IDLE   = 5'b00001,
		PH_HEADER = 5'b00010,
		PH_TAG    = 5'b00100,
		PH_VALUE  = 5'b01000,
		PH_DONE   = 5'b10000
	} phase_t;

	typedef enum logic {
		REG_HEADER_SKIP = 1'b0,
		REG_SIGNED_MODE = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [ByteW-1:0] header_skip;
		logic             signed_mode;
	} cfg_t;

	typedef struct packed {
		logic              valid;
		logic [ValueW-1:0] value_bits;
		status_t           status;
		logic [ByteW-1:0]  detail;
	} result_t;

	// value length in bytes, zero when the tag is rejected
	function automatic logic [LenW-1:0] tag_length(input logic [ByteW-1:0] tag,
		input logic sgn);
		logic [LenW-1:0] len;
		len = '0;
		unique case (tag)
			TAG_UINT8, TAG_ENUM: len = 4'd1;
			TAG_UINT16:          len = 4'd2;
			TAG_UINT32:          len = 4'd4;
			TAG_UINT64:          len = 4'd8;
			TAG_INT8:            len = sgn ? 4'd1 : 4'd0;
			TAG_INT16:           len = sgn ? 4'd2 : 4'd0;
			TAG_INT32:           len = sgn ? 4'd4 : 4'd0;
			TAG_INT64:           len = sgn ? 4'd8 : 4'd0;
			default:             len = 4'd0;
		endcase
		return len;
	endfunction

	function automatic logic [ValueW-1:0] extend(input logic [ValueW-1:0] v,
		input logic [ByteW-1:0] tag);
		logic [ValueW-1:0] r;
		r = v;
		unique case (tag)
			TAG_INT8:  r = {{56{v[7]}}, v[7:0]};
			TAG_INT16: r = {{48{v[15]}}, v[15:0]};
			TAG_INT32: r = {{32{v[31]}}, v[31:0]};
			default:   r = v;
		endcase
		return r;
	endfunction

endpackage

// ===== src/dlmstv_regs.sv =====
module dlmstv_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output dlmstv_pkg::cfg_t             cfg
);

	logic [dlmstv_pkg::ByteW-1:0] header_skip_q;
	logic                         signed_mode_q;
	logic                         wr_en;
	dlmstv_pkg::reg_idx_t         idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = dlmstv_pkg::reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_skip_q <= dlmstv_pkg::HeaderSkipRst;
			signed_mode_q <= dlmstv_pkg::SignedModeRst;
		end else if (wr_en) begin
			unique case (idx)
				dlmstv_pkg::REG_HEADER_SKIP: header_skip_q <= pwdata[7:0];
				dlmstv_pkg::REG_SIGNED_MODE: signed_mode_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			dlmstv_pkg::REG_HEADER_SKIP: prdata = {24'd0, header_skip_q};
			dlmstv_pkg::REG_SIGNED_MODE: prdata = {31'd0, signed_mode_q};
			default: prdata = '0;
		endcase
	end

	assign cfg.header_skip = header_skip_q;
	assign cfg.signed_mode = signed_mode_q;

endmodule

// ===== src/dlmstv_parser.sv =====
module dlmstv_parser (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [dlmstv_pkg::ByteW-1:0] rx_byte,
	input  logic                         frame_start,
	input  dlmstv_pkg::cfg_t             cfg,
	output dlmstv_pkg::result_t          res
);

	dlmstv_pkg::phase_t                phase_q, phase_d, phase_e;
	logic [dlmstv_pkg::ByteW-1:0]      cnt_q, cnt_d, cnt_e;
	logic [dlmstv_pkg::LenW-1:0]       left_q, left_d, left_e, left_m1, len;
	logic [dlmstv_pkg::ByteW-1:0]      tag_q, tag_d;
	logic [dlmstv_pkg::ValueW-1:0]     acc_q, acc_d, acc_e, acc_sh;

	always_comb begin
		phase_e = frame_start ? dlmstv_pkg::PH_HEADER : phase_q;
		cnt_e   = frame_start ? '0 : cnt_q;
		left_e  = frame_start ? '0 : left_q;
		acc_e   = frame_start ? '0 : acc_q;
		len     = dlmstv_pkg::tag_length(rx_byte, cfg.signed_mode);
		acc_sh  = {acc_e[dlmstv_pkg::ValueW-dlmstv_pkg::ByteW-1:0], rx_byte};
		left_m1 = left_e - 4'd1;

		phase_d = phase_e;
		cnt_d   = cnt_e;
		left_d  = left_e;
		tag_d   = tag_q;
		acc_d   = acc_e;
		res     = '0;
		res.status = dlmstv_pkg::STAT_OK;

		unique case (phase_e)
			dlmstv_pkg::PH_HEADER: begin
				if (cnt_e < cfg.header_skip) begin
					cnt_d = cnt_e + 8'd1;
				end else if (rx_byte != '0) begin
					res.valid  = 1'b1;
					res.status = dlmstv_pkg::STAT_ACCESS;
					res.detail = rx_byte;
					phase_d    = dlmstv_pkg::PH_DONE;
				end else begin
					phase_d = dlmstv_pkg::PH_TAG;
				end
			end
			dlmstv_pkg::PH_TAG: begin
				tag_d = rx_byte;
				if (len == '0) begin
					res.valid  = 1'b1;
					res.status = dlmstv_pkg::STAT_BAD_TAG;
					res.detail = rx_byte;
					phase_d    = dlmstv_pkg::PH_DONE;
				end else begin
					left_d  = len;
					acc_d   = '0;
					phase_d = dlmstv_pkg::PH_VALUE;
				end
			end
			dlmstv_pkg::PH_VALUE: begin
				acc_d  = acc_sh;
				left_d = left_m1;
				if (left_m1 == '0) begin
					res.valid      = 1'b1;
					res.value_bits = dlmstv_pkg::extend(acc_sh, tag_q);
					res.status     = dlmstv_pkg::STAT_OK;
					res.detail     = tag_q;
					phase_d        = dlmstv_pkg::PH_DONE;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dlmstv_pkg::PH_IDLE;
			cnt_q   <= '0;
			left_q  <= '0;
			tag_q   <= '0;
			acc_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			left_q  <= left_d;
			tag_q   <= tag_d;
			acc_q   <= acc_d;
		end
	end

endmodule

// ===== src/dlms_typed_value_decoder_unit.sv =====
// Throughput: one byte per cycle unless a held output result stalls the input;
// the parse state updates once per byte in a single stage between the input
// register and the result register.
// Reset (arst_n low, asynchronous): parser idle until a frame start,
// header_skip = 12, signed_mode = 0, both pipeline registers empty.
module dlms_typed_value_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  logic        s_axis_tuser,   // [0] frame_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // [63:0] value_bits, [71:64] detail
	output logic [1:0]  m_axis_tuser,   // [1:0] status
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	dlmstv_pkg::cfg_t             cfg;
	dlmstv_pkg::result_t          res;
	logic                         vld_s1, start_s1, adv;
	logic [dlmstv_pkg::ByteW-1:0] byte_s1;
	logic                         vld_s2;
	logic [71:0]                  data_s2;
	logic [1:0]                   user_s2;

	dlmstv_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign adv           = vld_s1 && (!vld_s2 || m_axis_tready);
	assign s_axis_tready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1  <= s_axis_tdata;
			start_s1 <= s_axis_tuser;
		end
	end

	dlmstv_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv),
		.rx_byte     (byte_s1),
		.frame_start (start_s1),
		.cfg         (cfg),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv && res.valid) begin
			vld_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.valid) begin
			data_s2 <= {res.detail, res.value_bits};
			user_s2 <= res.status;
		end
	end

	assign m_axis_tvalid = vld_s2;
	assign m_axis_tdata  = data_s2;
	assign m_axis_tuser  = user_s2;

endmodule

// ===== src/dlmstv_checker.sv =====
`include "dlms_typed_value_decoder_unit_assert.svh"

module dlmstv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [7:0]  s_axis_tdata,
	input logic        s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [71:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic        pready
);

	`DLMSTV_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

	`DLMSTV_ASSERT_SAME(a_status_legal, clk, arst_n, m_axis_tvalid,
		m_axis_tuser <= dlmstv_pkg::STAT_BAD_TAG)

	`DLMSTV_ASSERT_SAME(a_err_zero, clk, arst_n,
		m_axis_tvalid && (m_axis_tuser != dlmstv_pkg::STAT_OK),
		m_axis_tdata[63:0] == 64'd0)

	`DLMSTV_ASSERT_SAME(a_access_detail, clk, arst_n,
		m_axis_tvalid && (m_axis_tuser == dlmstv_pkg::STAT_ACCESS),
		m_axis_tdata[71:64] != 8'd0)

endmodule

bind dlms_typed_value_decoder_unit dlmstv_checker u_dlmstv_checker (.*);

// ===== tb/tb_dlms_typed_value_decoder_unit.sv =====
module tb_dlms_typed_value_decoder_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned STALL_LIMIT  = 4000;
	localparam int unsigned SETTLE_TICKS = 6;

	typedef struct {
		logic [7:0] data;
		logic       start;
	} rx_item_t;

	typedef struct {
		logic [63:0]         value;
		dlmstv_pkg::status_t status;
		logic [7:0]          detail;
	} decoded_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;   // [7:0] rx_byte
	logic        s_axis_tuser = 1'b0; // [0] frame_start
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;        // [63:0] value_bits, [71:64] detail
	logic [1:0]  m_axis_tuser;        // [1:0] status
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	dlms_typed_value_decoder_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	rx_item_t    rx_q[$];
	decoded_t    decoded_q[$];
	int unsigned queued = 0;
	int unsigned errors = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned stuck_cycles = 0;

	logic [7:0]  cfg_skip = dlmstv_pkg::HeaderSkipRst;
	logic        cfg_signed = dlmstv_pkg::SignedModeRst;

	dlmstv_pkg::phase_t dec_phase = dlmstv_pkg::PH_IDLE;
	logic [7:0]  hdr_cnt = '0;
	int unsigned len_left = 0;
	logic [7:0]  cur_tag = '0;
	logic [63:0] acc = '0;

	logic [7:0]  tag_set [9] = '{dlmstv_pkg::TAG_INT8, dlmstv_pkg::TAG_INT16,
		dlmstv_pkg::TAG_INT32, dlmstv_pkg::TAG_INT64, dlmstv_pkg::TAG_UINT8,
		dlmstv_pkg::TAG_ENUM, dlmstv_pkg::TAG_UINT16, dlmstv_pkg::TAG_UINT32,
		dlmstv_pkg::TAG_UINT64};

	function automatic int unsigned value_len(input logic [7:0] tag, input logic sgn);
		case (tag)
			dlmstv_pkg::TAG_UINT8, dlmstv_pkg::TAG_ENUM: return 1;
			dlmstv_pkg::TAG_UINT16: return 2;
			dlmstv_pkg::TAG_UINT32: return 4;
			dlmstv_pkg::TAG_UINT64: return 8;
			dlmstv_pkg::TAG_INT8:   return sgn ? 1 : 0;
			dlmstv_pkg::TAG_INT16:  return sgn ? 2 : 0;
			dlmstv_pkg::TAG_INT32:  return sgn ? 4 : 0;
			dlmstv_pkg::TAG_INT64:  return sgn ? 8 : 0;
			default:                return 0;
		endcase
	endfunction

	function automatic logic [63:0] widen(input logic [63:0] v, input logic [7:0] tag);
		case (tag)
			dlmstv_pkg::TAG_INT8:  return {{56{v[7]}}, v[7:0]};
			dlmstv_pkg::TAG_INT16: return {{48{v[15]}}, v[15:0]};
			dlmstv_pkg::TAG_INT32: return {{32{v[31]}}, v[31:0]};
			default:               return v;
		endcase
	endfunction

	task automatic post_result(input logic [63:0] value, input dlmstv_pkg::status_t st,
		input logic [7:0] detail);
		decoded_t r;
		r.value = value;
		r.status = st;
		r.detail = detail;
		decoded_q.push_back(r);
		dec_phase = dlmstv_pkg::PH_DONE;
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic start);
		int unsigned n;
		if (start) begin
			dec_phase = dlmstv_pkg::PH_HEADER;
			hdr_cnt = '0;
			len_left = 0;
			acc = '0;
		end
		case (dec_phase)
			dlmstv_pkg::PH_HEADER: begin
				if (hdr_cnt < cfg_skip)
					hdr_cnt = hdr_cnt + 8'd1;
				else if (b != 8'd0)
					post_result('0, dlmstv_pkg::STAT_ACCESS, b);
				else
					dec_phase = dlmstv_pkg::PH_TAG;
			end
			dlmstv_pkg::PH_TAG: begin
				cur_tag = b;
				n = value_len(b, cfg_signed);
				if (n == 0) begin
					post_result('0, dlmstv_pkg::STAT_BAD_TAG, b);
				end else begin
					len_left = n;
					acc = '0;
					dec_phase = dlmstv_pkg::PH_VALUE;
				end
			end
			dlmstv_pkg::PH_VALUE: begin
				acc = {acc[55:0], b};
				len_left = len_left - 1;
				if (len_left == 0)
					post_result(widen(acc, cur_tag), dlmstv_pkg::STAT_OK, cur_tag);
			end
			default: ;
		endcase
	endtask

	// driver
	always @(posedge clk) begin
		rx_item_t it;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				decode_byte(s_axis_tdata, s_axis_tuser);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (rx_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					it = rx_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= it.data;
					s_axis_tuser <= it.start;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		decoded_t e;
		if (arst_n) begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			if (m_axis_tvalid && m_axis_tready) begin
				if (decoded_q.size() == 0) begin
					$error("result with no pending transaction: value_bits %h status %0d detail %h",
						m_axis_tdata[63:0], m_axis_tuser, m_axis_tdata[71:64]);
					errors++;
				end else begin
					e = decoded_q.pop_front();
					if (m_axis_tdata[63:0] !== e.value) begin
						$error("value_bits: expected %h, got %h", e.value, m_axis_tdata[63:0]);
						errors++;
					end
					if (m_axis_tuser !== e.status) begin
						$error("status: expected %0d, got %0d", e.status, m_axis_tuser);
						errors++;
					end
					if (m_axis_tdata[71:64] !== e.detail) begin
						$error("detail: expected %h, got %h", e.detail, m_axis_tdata[71:64]);
						errors++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			!(rx_q.size() != 0 || s_axis_tvalid || decoded_q.size() != 0))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
	end

	initial begin
		wait (stuck_cycles >= STALL_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic push_byte(input logic [7:0] data, input logic start);
		rx_item_t it;
		it.data = data;
		it.start = start;
		rx_q.push_back(it);
		queued++;
	endtask

	function automatic logic [7:0] pick_byte();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 20) return 8'h00;
		if (r < 40) return 8'hFF;
		if (r < 47) return 8'h80;
		if (r < 54) return 8'h7F;
		return 8'($urandom);
	endfunction

	task automatic gen_frame(input logic [7:0] skip, input logic sgn);
		int unsigned kind;
		int unsigned n;
		int unsigned cut;
		logic [7:0]  tag;
		logic [7:0]  access;
		logic [7:0]  fb[$];
		kind = $urandom_range(99);
		if (kind >= 94) begin
			repeat ($urandom_range(1, 4)) push_byte(8'($urandom), 1'b0);
			return;
		end
		tag = tag_set[$urandom_range(8)];
		if (kind >= 78 && kind < 86)
			tag = 8'($urandom);
		access = (kind >= 70 && kind < 78) ? 8'($urandom_range(1, 255)) : 8'd0;
		repeat (skip) fb.push_back(8'($urandom));
		fb.push_back(access);
		if (access == 8'd0) begin
			fb.push_back(tag);
			n = value_len(tag, sgn);
			repeat (n) fb.push_back(pick_byte());
		end
		cut = fb.size();
		if (kind >= 86 && cut > 1)
			cut = $urandom_range(1, cut - 1);
		for (int unsigned i = 0; i < cut; i++)
			push_byte(fb[i], i == 0);
		if (kind < 86 && $urandom_range(99) < 15)
			repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0);
	endtask

	task automatic reg_write(input dlmstv_pkg::reg_idx_t idx, input logic [7:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == dlmstv_pkg::REG_HEADER_SKIP)
			cfg_skip = val;
		else
			cfg_signed = val[0];
	endtask

	task automatic drain_all();
		do @(negedge clk);
		while (rx_q.size() != 0 || s_axis_tvalid || decoded_q.size() != 0);
		repeat (SETTLE_TICKS) @(negedge clk);
	endtask

	initial begin
		logic [7:0]  skip;
		logic        sgn;
		int unsigned target;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: stray byte, then a frame failing on the access result
		push_byte(8'hA5, 1'b0);
		push_byte(8'hFF, 1'b1);
		repeat (11) push_byte(pick_byte(), 1'b0);
		push_byte(8'hFF, 1'b0);
		drain_all();

		// no header: the start byte carries the access result
		reg_write(dlmstv_pkg::REG_HEADER_SKIP, 8'd0);
		reg_write(dlmstv_pkg::REG_SIGNED_MODE, 8'd1);
		push_byte(8'h00, 1'b1);
		push_byte(dlmstv_pkg::TAG_INT8, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b1);
		push_byte(dlmstv_pkg::TAG_UINT16, 1'b0);
		push_byte(8'h12, 1'b0);
		push_byte(8'h01, 1'b1);
		push_byte(8'h5A, 1'b0);

		for (int unsigned p = 0; p < 8; p++) begin
			drain_all();
			case (p)
				0:       skip = 8'd0;
				4:       skip = 8'd255;
				6:       skip = dlmstv_pkg::HeaderSkipRst;
				default: skip = 8'($urandom_range(1, 8));
			endcase
			case (p)
				0:       sgn = 1'b0;
				4:       sgn = 1'b1;
				default: sgn = 1'($urandom_range(1));
			endcase
			reg_write(dlmstv_pkg::REG_HEADER_SKIP, skip);
			reg_write(dlmstv_pkg::REG_SIGNED_MODE, {7'd0, sgn});
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
				default: begin send_idle_pct = 32; recv_stall_pct = 32; end
			endcase
			// bytes that continue the frame left open by the last phase
			repeat ($urandom_range(0, 6)) push_byte(pick_byte(), 1'b0);
			target = queued + ((skip == 8'd255) ? 560 : 130);
			while (queued < target)
				gen_frame(skip, sgn);
			push_byte(pick_byte(), 1'b1);
			repeat ($urandom_range(0, 3)) push_byte(pick_byte(), 1'b0);
		end
		drain_all();

		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
